[hw/rtl/ssbf_pkg.sv]
// ----------------------------------------------------------------------------
// ssbf_pkg
// Shared types, constants and codes for the SPI slave byte FIFO block.
// ----------------------------------------------------------------------------
package ssbf_pkg;

  localparam int unsigned BufferDepth = 16;
  localparam int unsigned PtrW        = $clog2(BufferDepth);
  localparam int unsigned CntW        = $clog2(BufferDepth + 1);
  localparam int unsigned CfgIdxW     = 4;

  localparam logic [7:0] FillerReset = 8'hFD;
  localparam logic [7:0] EmptyReset  = 8'hFE;

  localparam logic [CfgIdxW-1:0] CfgFillerByte = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgEmptyCode  = CfgIdxW'(1);

  typedef enum logic [1:0] {
    CmdTransfer = 2'd0,
    CmdRead     = 2'd1,
    CmdWrite    = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] shift_out;
    logic       handshake;
    logic       rx_not_empty;
    logic       write_accepted;
    logic       rx_dropped;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [7:0]      head;
  } fifo_stat_t;

endpackage

[hw/rtl/ssbf_fifo.sv]
// ----------------------------------------------------------------------------
// ssbf_fifo
// Byte FIFO in flops with a fill count, push and pop in the same cycle.
// ----------------------------------------------------------------------------
module ssbf_fifo import ssbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fifo_ctrl_t ctrl_i,
  input  logic [7:0] wdata_i,
  output fifo_stat_t stat_o
);

  logic [7:0]      mem_q [BufferDepth];
  logic [PtrW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(BufferDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    rd_d  = ctrl_i.pop  ? next_ptr(rd_q) : rd_q;
    wr_d  = ctrl_i.push ? next_ptr(wr_q) : wr_q;
    cnt_d = cnt_q + CntW'(ctrl_i.push) - CntW'(ctrl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign stat_o.count = cnt_q;
  assign stat_o.head  = mem_q[rd_q];

endmodule

[hw/rtl/ssbf_step.sv]
// ----------------------------------------------------------------------------
// ssbf_step
// Event decode: FIFO control, shift register and handshake update, result.
// ----------------------------------------------------------------------------
module ssbf_step import ssbf_pkg::*; (
  input  in_item_t   item_i,
  input  logic [7:0] filler_i,
  input  logic [7:0] empty_code_i,
  input  logic [7:0] shift_i,
  input  logic       ready_i,
  input  fifo_stat_t rx_i,
  input  fifo_stat_t tx_i,
  output fifo_ctrl_t rx_ctrl_o,
  output fifo_ctrl_t tx_ctrl_o,
  output logic [7:0] shift_d_o,
  output logic       ready_d_o,
  output out_item_t  result_o
);

  logic            rx_full, tx_full;
  logic [CntW-1:0] rx_cnt_next, tx_cnt_after_push;

  assign rx_full = (rx_i.count == CntW'(BufferDepth));
  assign tx_full = (tx_i.count == CntW'(BufferDepth));

  always_comb begin
    rx_ctrl_o         = '0;
    tx_ctrl_o         = '0;
    shift_d_o         = shift_i;
    ready_d_o         = ready_i;
    result_o          = '0;
    tx_cnt_after_push = tx_i.count;
    unique case (item_i.command)
      CmdTransfer: begin
        ready_d_o = 1'b0;
        if (item_i.data_in != filler_i) begin
          if (rx_full) begin
            result_o.rx_dropped = 1'b1;
          end else begin
            rx_ctrl_o.push = 1'b1;
          end
        end
        if (tx_i.count != '0) begin
          tx_ctrl_o.pop = 1'b1;
          shift_d_o     = tx_i.head;
          ready_d_o     = 1'b1;
        end else begin
          shift_d_o = filler_i;
        end
      end
      CmdRead: begin
        if (rx_i.count != '0) begin
          rx_ctrl_o.pop      = 1'b1;
          result_o.read_data = rx_i.head;
        end else begin
          result_o.read_data = empty_code_i;
        end
      end
      CmdWrite: begin
        if (!tx_full) begin
          tx_ctrl_o.push          = 1'b1;
          result_o.write_accepted = 1'b1;
          tx_cnt_after_push       = tx_i.count + CntW'(1);
        end
        // kick-start when nothing real is loaded
        if (!ready_i && tx_cnt_after_push != '0) begin
          tx_ctrl_o.pop = 1'b1;
          shift_d_o     = (tx_i.count == '0) ? item_i.data_in : tx_i.head;
          ready_d_o     = 1'b1;
        end
      end
      CmdNone: begin
      end
      default: begin
      end
    endcase
    rx_cnt_next           = rx_i.count + CntW'(rx_ctrl_o.push) - CntW'(rx_ctrl_o.pop);
    result_o.shift_out    = shift_d_o;
    result_o.handshake    = ready_d_o;
    result_o.rx_not_empty = (rx_cnt_next != '0);
  end

endmodule

[hw/rtl/spi_slave_byte_fifos_top.sv]
// ----------------------------------------------------------------------------
// spi_slave_byte_fifos_top
// SPI slave byte buffering with receive and transmit FIFOs.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one event per transfer (completed SPI transfer, host read
//                 or host write), command and byte in in_data_i
//   out channel : one result per event: read byte, shift register, handshake
//                 and status flags after that event
//   cfg channel : writes filler byte (index 0) and empty code (index 1);
//                 always ready, other indexes are ignored
// An input register, then the event logic and the result register, lie
// between input transfer and result valid. Throughput is one event per
// cycle while the receiver does not stall, set by the FIFO pointer and
// count update that each event reads and writes.
// If the receiver stalls, the result register holds and the input register
// keeps one more event; input ready drops once both are occupied.
// Reset empties both FIFOs, loads the shift register with the filler reset
// value, drops the handshake and restores the configuration defaults.
// ----------------------------------------------------------------------------
module spi_slave_byte_fifos_top import ssbf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  in_item_t   in_q;
  logic       in_valid_q;
  out_item_t  out_q, result;
  logic       out_valid_q;
  logic [7:0] filler_q, empty_code_q;
  logic [7:0] shift_q, shift_d;
  logic       ready_q, ready_d;
  logic       advance, step_fire;
  fifo_ctrl_t rx_ctrl, tx_ctrl, rx_ctrl_g, tx_ctrl_g;
  fifo_stat_t rx_stat, tx_stat;

  assign advance     = !out_valid_q || out_ready_i;
  assign step_fire   = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign rx_ctrl_g   = step_fire ? rx_ctrl : '0;
  assign tx_ctrl_g   = step_fire ? tx_ctrl : '0;

  ssbf_fifo u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (rx_ctrl_g),
    .wdata_i (in_q.data_in),
    .stat_o  (rx_stat)
  );

  ssbf_fifo u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tx_ctrl_g),
    .wdata_i (in_q.data_in),
    .stat_o  (tx_stat)
  );

  ssbf_step u_step (
    .item_i       (in_q),
    .filler_i     (filler_q),
    .empty_code_i (empty_code_q),
    .shift_i      (shift_q),
    .ready_i      (ready_q),
    .rx_i         (rx_stat),
    .tx_i         (tx_stat),
    .rx_ctrl_o    (rx_ctrl),
    .tx_ctrl_o    (tx_ctrl),
    .shift_d_o    (shift_d),
    .ready_d_o    (ready_d),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      shift_q      <= FillerReset;
      ready_q      <= 1'b0;
      filler_q     <= FillerReset;
      empty_code_q <= EmptyReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step_fire) begin
        shift_q <= shift_d;
        ready_q <= ready_d;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgFillerByte) begin
          filler_q <= cfg_data_i;
        end
        if (cfg_index_i == CfgEmptyCode) begin
          empty_code_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step_fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stat.count <= CntW'(BufferDepth))
    else $error("rx fifo count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_stat.count <= CntW'(BufferDepth))
    else $error("tx fifo count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> out_valid_q)
    else $error("event processed without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && in_q.command == CmdWrite) |=> ready_q)
    else $error("handshake low after host write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(ready_q) |-> $past(step_fire && in_q.command == CmdTransfer))
    else $error("handshake dropped outside a transfer");

endmodule

[tb/sv/spi_slave_byte_fifos_top_tb.sv]
// ----------------------------------------------------------------------------
// spi_slave_byte_fifos_top_tb
// Self-checking bench for the SPI slave byte FIFO block. A short table of
// directed events comes first, then biased random traffic under several
// filler and empty-code settings. Every result is checked field by field
// against the table's own results or a cycle-free model of both FIFOs, the
// shift register and handshake line. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module spi_slave_byte_fifos_top_tb import ssbf_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned PhaseOps    = 225;
  localparam int unsigned Phases      = 6;
  localparam int unsigned MaxPrinted  = 30;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data;
    logic [4:0] reps;
    logic       stepped;
    logic       typed;
    out_item_t  res;
  } dir_row_t;

  localparam int unsigned DirRows = 10;
  localparam dir_row_t DirTable [DirRows] = '{
    '{CmdRead,     8'h00, 5'd1,  1'b0, 1'b1, '{8'hFE, 8'hFD, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{CmdNone,     8'hFF, 5'd1,  1'b0, 1'b1, '{8'h00, 8'hFD, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{CmdTransfer, 8'hFD, 5'd1,  1'b0, 1'b1, '{8'h00, 8'hFD, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{CmdTransfer, 8'h00, 5'd1,  1'b0, 1'b1, '{8'h00, 8'hFD, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{CmdRead,     8'h00, 5'd1,  1'b0, 1'b1, '{8'h00, 8'hFD, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{CmdWrite,    8'hFF, 5'd1,  1'b0, 1'b1, '{8'h00, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{CmdWrite,    8'h00, 5'd1,  1'b0, 1'b1, '{8'h00, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{CmdTransfer, 8'h55, 5'd1,  1'b0, 1'b0, '0},
    '{CmdTransfer, 8'h10, 5'd16, 1'b1, 1'b0, '0},
    '{CmdTransfer, 8'h80, 5'd1,  1'b0, 1'b1, '{8'h00, 8'hFD, 1'b0, 1'b1, 1'b0, 1'b1}}
  };

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  in_item_t           in_data    = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  out_item_t          out_data;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [7:0]         cfg_data   = '0;

  spi_slave_byte_fifos_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // buffer model state
  logic [7:0]  rx_mem [BufferDepth];
  logic [7:0]  tx_mem [BufferDepth];
  int unsigned rx_rd = 0, rx_wr = 0, rx_cnt = 0;
  int unsigned tx_rd = 0, tx_wr = 0, tx_cnt = 0;
  logic [7:0]  cur_filler = FillerReset;
  logic [7:0]  cur_empty  = EmptyReset;
  logic [7:0]  shift_q    = FillerReset;
  logic        hs_q       = 1'b0;

  out_item_t   awaited_status [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned ops_sent     = 0;

  function automatic logic [7:0] tx_take();
    logic [7:0] b;
    b     = tx_mem[tx_rd];
    tx_rd = (tx_rd + 1) % BufferDepth;
    tx_cnt--;
    return b;
  endfunction

  function automatic out_item_t predict_buffer_step(in_item_t op);
    out_item_t r;
    r = '0;
    case (op.command)
      CmdTransfer: begin
        hs_q = 1'b0;
        if (op.data_in != cur_filler) begin
          if (rx_cnt < BufferDepth) begin
            rx_mem[rx_wr] = op.data_in;
            rx_wr         = (rx_wr + 1) % BufferDepth;
            rx_cnt++;
          end else begin
            r.rx_dropped = 1'b1;
          end
        end
        if (tx_cnt > 0) begin
          shift_q = tx_take();
          hs_q    = 1'b1;
        end else begin
          shift_q = cur_filler;
        end
      end
      CmdRead: begin
        if (rx_cnt > 0) begin
          r.read_data = rx_mem[rx_rd];
          rx_rd       = (rx_rd + 1) % BufferDepth;
          rx_cnt--;
        end else begin
          r.read_data = cur_empty;
        end
      end
      CmdWrite: begin
        if (tx_cnt < BufferDepth) begin
          tx_mem[tx_wr]    = op.data_in;
          tx_wr            = (tx_wr + 1) % BufferDepth;
          tx_cnt++;
          r.write_accepted = 1'b1;
        end
        // kick-start when nothing real is loaded
        if (!hs_q && tx_cnt > 0) begin
          shift_q = tx_take();
          hs_q    = 1'b1;
        end
      end
      CmdNone: begin
      end
      default: begin
      end
    endcase
    r.shift_out    = shift_q;
    r.handshake    = hs_q;
    r.rx_not_empty = (rx_cnt != 0);
    return r;
  endfunction

  function automatic int unsigned pick_gap(int unsigned n);
    int unsigned r;
    if ((n / 40) % 5 == 4) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t random_op(int unsigned mode);
    in_item_t    op;
    int unsigned w_xfer;
    int unsigned w_read;
    int unsigned r;
    case (mode)
      1:       begin w_xfer = 15; w_read = 15; end
      2:       begin w_xfer = 70; w_read = 10; end
      3:       begin w_xfer = 25; w_read = 60; end
      default: begin w_xfer = 34; w_read = 33; end
    endcase
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) op.command = CmdNone;
    else if (r < w_xfer) op.command = CmdTransfer;
    else if (r < w_xfer + w_read) op.command = CmdRead;
    else op.command = CmdWrite;
    if ($urandom_range(0, 7) == 0) op.data_in = cur_filler;
    else op.data_in = 8'($urandom_range(0, 255));
    return op;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch %s: got %0h want %0h at result %0d", what, got, want, results_seen);
  endtask

  task automatic send_op(in_item_t op, logic typed, out_item_t typed_res);
    int unsigned gap;
    out_item_t   pred;
    gap = pick_gap(ops_sent);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    pred = predict_buffer_step(op);
    awaited_status.push_back(typed ? typed_res : pred);
    ops_sent++;
  endtask

  // sender pauses until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_status.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgFillerByte) cur_filler = value;
    else if (idx == CfgEmptyCode) cur_empty = value;
  endtask

  // result checking and receiver stalls
  int unsigned stall_left = 0;
  int unsigned rx_cycle   = 0;
  out_item_t   want;

  always @(posedge clk) begin
    rx_cycle++;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (awaited_status.size() == 0) begin
        report_mismatch("result with none awaited", 32'(out_data), 0);
      end else begin
        want = awaited_status.pop_front();
        if (out_data.read_data != want.read_data)
          report_mismatch("read_data", 32'(out_data.read_data), 32'(want.read_data));
        if (out_data.shift_out != want.shift_out)
          report_mismatch("shift_out", 32'(out_data.shift_out), 32'(want.shift_out));
        if (out_data.handshake != want.handshake)
          report_mismatch("handshake", 32'(out_data.handshake), 32'(want.handshake));
        if (out_data.rx_not_empty != want.rx_not_empty)
          report_mismatch("rx_not_empty", 32'(out_data.rx_not_empty), 32'(want.rx_not_empty));
        if (out_data.write_accepted != want.write_accepted)
          report_mismatch("write_accepted", 32'(out_data.write_accepted),
                          32'(want.write_accepted));
        if (out_data.rx_dropped != want.rx_dropped)
          report_mismatch("rx_dropped", 32'(out_data.rx_dropped), 32'(want.rx_dropped));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ((rx_cycle / 256) % 4 == 3) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b0;
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    end
  end

  // watchdog on cycles without any transfer
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    in_item_t    op;
    int unsigned mode;
    logic [7:0]  f;
    logic [7:0]  e;
    mode = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirRows; i++) begin
      for (int k = 0; k < int'(DirTable[i].reps); k++) begin
        op.command = DirTable[i].command;
        op.data_in = DirTable[i].data + (DirTable[i].stepped ? 8'(k) : 8'd0);
        send_op(op, DirTable[i].typed, DirTable[i].res);
      end
    end

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       begin f = 8'h00;       e = 8'hFF;       end
        1:       begin f = 8'hFF;       e = 8'h00;       end
        3:       begin f = FillerReset; e = EmptyReset;  end
        default: begin f = 8'($urandom); e = 8'($urandom); end
      endcase
      write_reg(CfgFillerByte, f);
      write_reg(CfgEmptyCode, e);
      for (int n = 0; n < PhaseOps; n++) begin
        if (n % 48 == 0) mode = $urandom_range(0, 3);
        if (n == 100 && p % 2 == 0) wait_drained();
        send_op(random_op(mode), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
